### rtl/sidx_pkg.sv
// sidx_pkg: shared constants, register codes and the divider cell payload
// for the spectral index unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sidx_pkg;

  localparam int BAND_BITS  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_BANDS  = 5;
  localparam int SOIL_W     = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int ONE_FX = 1 << FRAC_BITS;

  // width of ONE + soil factor
  localparam int OPL_W = ((FRAC_BITS > SOIL_W) ? FRAC_BITS : SOIL_W) + 1;
  // magnitude widths of numerator and denominator over all modes
  localparam int NUM_W = BAND_BITS + OPL_W + 2;
  localparam int DEN_W = ((BAND_BITS > FRAC_BITS) ? BAND_BITS : FRAC_BITS) + 5;
  localparam int NS    = NUM_W + 1;
  localparam int DS    = DEN_W + 1;

  // quotient bits: one overflow bit, the integer bit and the fraction
  localparam int QBITS = FRAC_BITS + 2;
  localparam int OUT_W = QBITS;
  localparam int DIV_W = DEN_W + QBITS - 1;
  localparam int CMP_W = (NUM_W > DIV_W) ? NUM_W : DIV_W;

  localparam int IN_TD_W  = ((NUM_BANDS * BAND_BITS + 7) / 8) * 8;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [SOIL_W-1:0] SOIL_RESET = SOIL_W'(8192);
  localparam logic signed [OUT_W-1:0] ONE_S     = OUT_W'(ONE_FX);
  localparam logic signed [OUT_W-1:0] NEG_ONE_S = -OUT_W'(ONE_FX);

  typedef enum logic [MODE_W-1:0] {
    MODE_NDVI = MODE_W'(0),
    MODE_EVI  = MODE_W'(1),
    MODE_SAVI = MODE_W'(2),
    MODE_NDWI = MODE_W'(3),
    MODE_NBR  = MODE_W'(4)
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_MODE  = CFG_IDX_W'(0),
    CFG_SOIL_FACTOR = CFG_IDX_W'(1)
  } cfg_reg_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [CMP_W-1:0] dvs;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             zero;
  } cell_t;

endpackage

`default_nettype wire

### rtl/spectral_index_unit.sv
// spectral_index_unit: top level, configuration registers, front end,
// row of divider cells and output stage; uses sidx_pkg, sidx_form,
// sidx_cell and sidx_out
//
//   channel  | dir | payload                           | transfer when
//   s_axis   | in  | red, nir, blue, green, swir bands | s_axis_tvalid & s_axis_tready
//   m_axis   | out | index_value, zero_denominator    | m_axis_tvalid & m_axis_tready
//   cfg      | in  | cfg_index, cfg_data               | cfg_valid & cfg_ready
//
// one pixel per cycle while the output is not stalled; the pipeline is 2 front
// stages + QBITS divider cells (16) + 1 output register, one quotient bit per cell
// every stage has its own valid and ready, so bubbles close up under a stall
// and new pixels are still taken while the output waits, until all 19 stages are full
// reset clears valid bits and loads index_mode 0, soil_factor 0.5
// cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module spectral_index_unit
  import sidx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // red_band, nir_band, blue_band, green_band, swir_band from bit 0 up
  input  wire logic [IN_TD_W-1:0]    s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // index_value
  output logic [OUT_TD_W-1:0]        m_axis_tdata,
  // zero_denominator
  output logic [0:0]                 m_axis_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0] index_mode;
  logic [SOIL_W-1:0] soil_factor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mode  <= MODE_NDVI;
      soil_factor <= SOIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INDEX_MODE:  index_mode  <= cfg_data[MODE_W-1:0];
        CFG_SOIL_FACTOR: soil_factor <= cfg_data[SOIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic  chain_valid [QBITS+1];
  logic  chain_ready [QBITS+1];
  cell_t chain_data  [QBITS+1];

  sidx_form u_form (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (s_axis_tvalid),
    .up_ready    (s_axis_tready),
    .red_band    (s_axis_tdata[0*BAND_BITS +: BAND_BITS]),
    .nir_band    (s_axis_tdata[1*BAND_BITS +: BAND_BITS]),
    .blue_band   (s_axis_tdata[2*BAND_BITS +: BAND_BITS]),
    .green_band  (s_axis_tdata[3*BAND_BITS +: BAND_BITS]),
    .swir_band   (s_axis_tdata[4*BAND_BITS +: BAND_BITS]),
    .index_mode  (index_mode),
    .soil_factor (soil_factor),
    .dn_valid    (chain_valid[0]),
    .dn_ready    (chain_ready[0]),
    .dn_data     (chain_data[0])
  );

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    sidx_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  logic signed [OUT_W-1:0] index_value;
  logic                    zero_denominator;

  sidx_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[QBITS]),
    .up_ready (chain_ready[QBITS]),
    .up_data  (chain_data[QBITS]),
    .dn_valid (m_axis_tvalid),
    .dn_ready (m_axis_tready),
    .value    (index_value),
    .zero     (zero_denominator)
  );

  assign m_axis_tdata    = OUT_TD_W'($unsigned(index_value));
  assign m_axis_tuser[0] = zero_denominator;

  // a zero denominator always comes out as zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && zero_denominator |-> index_value == '0)
    else $error("zero denominator with nonzero index value");

  // clipping keeps the result within plus or minus one
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (index_value <= ONE_S) && (index_value >= NEG_ONE_S))
    else $error("index value beyond plus or minus one");

  // flagged items carry a zero numerator through the whole cell row
  assert property (@(posedge clk) disable iff (rst)
    chain_valid[QBITS] && chain_data[QBITS].zero |-> chain_data[QBITS].quo == '0)
    else $error("flagged item produced a nonzero quotient");

  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

### rtl/sidx_form.sv
// sidx_form: forms numerator and denominator of the selected index, then
// their magnitudes and sign for the divider chain; uses sidx_pkg
`timescale 1ns / 1ps
`default_nettype none

module sidx_form
  import sidx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic [BAND_BITS-1:0] red_band,
  input  wire logic [BAND_BITS-1:0] nir_band,
  input  wire logic [BAND_BITS-1:0] blue_band,
  input  wire logic [BAND_BITS-1:0] green_band,
  input  wire logic [BAND_BITS-1:0] swir_band,
  input  wire logic [MODE_W-1:0]    index_mode,
  input  wire logic [SOIL_W-1:0]    soil_factor,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output cell_t                     dn_data
);

  localparam logic signed [DS-1:0] TWO_ONE = DS'(2 * ONE_FX);

  logic                   a_valid;
  logic                   a_ready;
  logic                   up_ready_b;
  logic signed [NS-1:0]   num_a;
  logic signed [DS-1:0]   den_a;
  logic                   zero_a;
  logic signed [NS-1:0]   num_next;
  logic signed [DS-1:0]   den_next;
  logic                   zero_next;
  cell_t                  b_next;

  logic signed [DS-1:0]   red_s, nir_s, blue_s, green_s, swir_s, soil_s;
  logic signed [DS-1:0]   diff_nr, sum_nr, diff_gn, sum_gn, diff_ns, sum_ns;
  logic signed [DS-1:0]   evi_num, evi_den, savi_den;
  logic signed [BAND_BITS:0] diff_narrow;
  logic [OPL_W-1:0]       one_plus_l;
  logic signed [BAND_BITS+OPL_W+1:0] savi_prod;
  logic signed [NS-1:0]   num_sel;
  logic signed [DS-1:0]   den_sel;
  logic                   mode_ok;
  logic signed [NS-1:0]   num_neg;
  logic signed [DS-1:0]   den_neg;
  logic [NUM_W-1:0]       num_mag;
  logic [DEN_W-1:0]       den_mag;

  always_comb begin
    red_s   = $signed({{(DS-BAND_BITS){1'b0}}, red_band});
    nir_s   = $signed({{(DS-BAND_BITS){1'b0}}, nir_band});
    blue_s  = $signed({{(DS-BAND_BITS){1'b0}}, blue_band});
    green_s = $signed({{(DS-BAND_BITS){1'b0}}, green_band});
    swir_s  = $signed({{(DS-BAND_BITS){1'b0}}, swir_band});
    soil_s  = $signed({{(DS-SOIL_W){1'b0}}, soil_factor});

    diff_nr = nir_s - red_s;
    sum_nr  = nir_s + red_s;
    diff_gn = green_s - nir_s;
    sum_gn  = green_s + nir_s;
    diff_ns = nir_s - swir_s;
    sum_ns  = nir_s + swir_s;

    // evi with both terms doubled: 5(n-r) / (2n + 12r - 15b + 2)
    evi_num = (diff_nr <<< 2) + diff_nr;
    evi_den = (nir_s <<< 1) + (red_s <<< 3) + (red_s <<< 2)
              - (blue_s <<< 4) + blue_s + TWO_ONE;
    savi_den = sum_nr + soil_s;

    diff_narrow = diff_nr[BAND_BITS:0];
    one_plus_l  = OPL_W'(ONE_FX) + OPL_W'(soil_factor);
    savi_prod   = diff_narrow * $signed({1'b0, one_plus_l});

    mode_ok = 1'b1;
    num_sel = '0;
    den_sel = '0;
    case (index_mode)
      MODE_NDVI: begin
        num_sel = NS'(diff_nr) <<< FRAC_BITS;
        den_sel = sum_nr;
      end
      MODE_EVI: begin
        num_sel = NS'(evi_num) <<< FRAC_BITS;
        den_sel = evi_den;
      end
      MODE_SAVI: begin
        num_sel = NS'(savi_prod);
        den_sel = savi_den;
      end
      MODE_NDWI: begin
        num_sel = NS'(diff_gn) <<< FRAC_BITS;
        den_sel = sum_gn;
      end
      MODE_NBR: begin
        num_sel = NS'(diff_ns) <<< FRAC_BITS;
        den_sel = sum_ns;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    // zero denominator and unused modes both divide 0 by 1
    zero_next = mode_ok && (den_sel == '0);
    if (!mode_ok || zero_next) begin
      num_next = '0;
      den_next = DS'(1);
    end else begin
      num_next = num_sel;
      den_next = den_sel;
    end
  end

  assign a_ready  = !a_valid || up_ready_b;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      num_a  <= num_next;
      den_a  <= den_next;
      zero_a <= zero_next;
    end
  end

  // second stage: magnitudes, sign, and divisor aligned to the top quotient bit
  always_comb begin
    num_neg = -num_a;
    den_neg = -den_a;
    num_mag = num_a[NS-1] ? num_neg[NUM_W-1:0] : num_a[NUM_W-1:0];
    den_mag = den_a[DS-1] ? den_neg[DEN_W-1:0] : den_a[DEN_W-1:0];
    b_next.rem  = CMP_W'(num_mag);
    b_next.dvs  = CMP_W'(den_mag) << (QBITS - 1);
    b_next.quo  = '0;
    b_next.neg  = num_a[NS-1] ^ den_a[DS-1];
    b_next.zero = zero_a;
  end

  assign up_ready_b = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready_b) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_b && a_valid) begin
      dn_data <= b_next;
    end
  end

endmodule

`default_nettype wire

### rtl/sidx_cell.sv
// sidx_cell: one restoring divide step, yields one quotient bit and hands
// remainder and halved divisor to the next cell; uses sidx_pkg
`timescale 1ns / 1ps
`default_nettype none

module sidx_cell
  import sidx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire cell_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output cell_t      dn_data
);

  logic [CMP_W:0] trial;
  logic           take;
  cell_t          step_next;

  always_comb begin
    trial = {1'b0, up_data.rem} - {1'b0, up_data.dvs};
    take  = !trial[CMP_W];
    step_next.rem  = take ? trial[CMP_W-1:0] : up_data.rem;
    step_next.dvs  = up_data.dvs >> 1;
    step_next.quo  = {up_data.quo[QBITS-2:0], take};
    step_next.neg  = up_data.neg;
    step_next.zero = up_data.zero;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= step_next;
    end
  end

endmodule

`default_nettype wire

### rtl/sidx_out.sv
// sidx_out: applies sign and clips the quotient to plus or minus one,
// holds the result register; uses sidx_pkg
`timescale 1ns / 1ps
`default_nettype none

module sidx_out
  import sidx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire cell_t             up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic signed [OUT_W-1:0] value,
  output logic                   zero
);

  logic                    over;
  logic [QBITS-2:0]        mag;
  logic signed [OUT_W-1:0] mag_s;
  logic signed [OUT_W-1:0] value_next;

  always_comb begin
    // top quotient bit set means the true quotient is at least two
    over  = up_data.quo[QBITS-1] || (up_data.quo[QBITS-2:0] > (QBITS-1)'(ONE_FX));
    mag   = over ? (QBITS-1)'(ONE_FX) : up_data.quo[QBITS-2:0];
    mag_s = $signed({1'b0, mag});
    value_next = up_data.neg ? -mag_s : mag_s;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      value <= value_next;
      zero  <= up_data.zero;
    end
  end

endmodule

`default_nettype wire

### sim/spectral_index_unit_test.sv
// spectral_index_unit_test: self-checking bench for the spectral index unit,
// directed table then random pixels per index mode, scored by a local predictor
// depends on sidx_pkg and spectral_index_unit
`timescale 1ns / 1ps

module spectral_index_unit_test;
  import sidx_pkg::*;

  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT     = 325;
  localparam int QUIET_FIRST = 450;
  localparam int QUIET_LAST  = 560;
  localparam int STALL_LIMIT = 2000;
  localparam int END_CYCLES  = 40;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 50;
  localparam int N_DIRECTED  = 24;
  localparam int MAX_REPORTS = 10;

  // red in the low bits, swir in the high bits, same as s_axis_tdata
  typedef struct packed {
    logic [BAND_BITS-1:0] swir;
    logic [BAND_BITS-1:0] green;
    logic [BAND_BITS-1:0] blue;
    logic [BAND_BITS-1:0] nir;
    logic [BAND_BITS-1:0] red;
  } bands_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    zero_den;
  } index_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SOIL_W-1:0]       soil;
    logic [BAND_BITS-1:0]    red;
    logic [BAND_BITS-1:0]    nir;
    logic [BAND_BITS-1:0]    blue;
    logic [BAND_BITS-1:0]    green;
    logic [BAND_BITS-1:0]    swir;
    logic                    typed;
    logic signed [OUT_W-1:0] value;
    logic                    zero_den;
  } dir_row_t;

  // mode, soil, red, nir, blue, green, swir, typed, value, zero_den
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{0, 8192, 0, 0, 0, 0, 0, 1, 0, 1},
    '{0, 8192, 0, 65535, 0, 0, 0, 1, 16384, 0},
    '{0, 8192, 65535, 0, 65535, 65535, 65535, 1, -16384, 0},
    '{0, 8192, 65535, 65535, 0, 0, 0, 1, 0, 0},
    '{0, 8192, 3000, 12000, 777, 4000, 9000, 0, 0, 0},
    '{1, 8192, 0, 11, 2186, 0, 0, 1, 0, 1},
    '{1, 8192, 0, 65535, 0, 0, 0, 1, 16384, 0},
    '{1, 8192, 0, 1000, 2600, 0, 0, 1, -16384, 0},
    '{1, 8192, 5000, 20000, 3000, 0, 0, 0, 0, 0},
    '{1, 8192, 65535, 65535, 65535, 65535, 65535, 0, 0, 0},
    '{2, 8192, 0, 65535, 0, 0, 0, 1, 16384, 0},
    '{2, 8192, 10000, 30000, 0, 0, 0, 0, 0, 0},
    '{2, 0, 0, 0, 65535, 65535, 65535, 1, 0, 1},
    '{2, 65535, 65535, 0, 0, 0, 0, 1, -16384, 0},
    '{2, 65535, 1000, 40000, 123, 456, 789, 0, 0, 0},
    '{3, 65535, 0, 0, 0, 0, 0, 1, 0, 1},
    '{3, 65535, 0, 0, 0, 65535, 0, 1, 16384, 0},
    '{3, 65535, 0, 20000, 0, 5000, 0, 0, 0, 0},
    '{4, 65535, 0, 0, 0, 0, 0, 1, 0, 1},
    '{4, 65535, 0, 0, 0, 0, 65535, 1, -16384, 0},
    '{4, 65535, 0, 25000, 0, 0, 9000, 0, 0, 0},
    '{5, 65535, 65535, 65535, 65535, 65535, 65535, 1, 0, 0},
    '{7, 65535, 1234, 5678, 910, 1112, 1314, 1, 0, 0},
    '{6, 0, 0, 0, 0, 0, 0, 1, 0, 0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TD_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TD_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_INDEX_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies as the block should hold them
  logic [MODE_W-1:0] cur_mode = MODE_NDVI;
  logic [SOIL_W-1:0] cur_soil = SOIL_RESET;

  index_result_t pending_indices[$];
  int  pixels_sent;
  int  results_seen;
  int  typed_rows;
  int  zero_flags;
  int  clipped;
  int  config_count;
  int  mismatch_count;
  int  stall_cycles;
  bit  hold_request;
  bit  hold_done;

  spectral_index_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic index_result_t predict_index(bands_t b);
    longint red, nir, blue, green, swir, soil, num, den, scale, q;
    index_result_t res;
    red   = b.red;
    nir   = b.nir;
    blue  = b.blue;
    green = b.green;
    swir  = b.swir;
    soil  = cur_soil;
    scale = ONE_FX;
    res   = '0;
    case (cur_mode)
      MODE_NDVI: begin
        num = nir - red;
        den = nir + red;
      end
      MODE_EVI: begin
        // 2.5, 6, 7.5 and 1.0 all doubled to stay integral
        num = 5 * (nir - red);
        den = 2 * nir + 12 * red - 15 * blue + 2 * ONE_FX;
      end
      MODE_SAVI: begin
        num   = (nir - red) * (ONE_FX + soil);
        den   = nir + red + soil;
        scale = 1;
      end
      MODE_NDWI: begin
        num = green - nir;
        den = green + nir;
      end
      MODE_NBR: begin
        num = nir - swir;
        den = nir + swir;
      end
      default: return res;
    endcase
    if (den == 0) begin
      res.zero_den = 1'b1;
      return res;
    end
    q = (num * scale) / den;
    if (q > ONE_FX) q = ONE_FX;
    else if (q < -ONE_FX) q = -ONE_FX;
    res.value = OUT_W'(q);
    return res;
  endfunction

  function automatic bit in_quiet_stretch();
    return pixels_sent >= QUIET_FIRST && pixels_sent < QUIET_LAST;
  endfunction

  function automatic logic [BAND_BITS-1:0] pick_band();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return BAND_BITS'($urandom_range(255));
      default: return BAND_BITS'($urandom);
    endcase
  endfunction

  function automatic bands_t random_bands();
    bands_t b;
    longint t;
    b.red   = pick_band();
    b.nir   = pick_band();
    b.blue  = pick_band();
    b.green = pick_band();
    b.swir  = pick_band();
    if (cur_mode == MODE_EVI && $urandom_range(15) == 0) begin
      // pick blue so the evi denominator cancels exactly
      b.nir = BAND_BITS'($urandom_range(4000));
      b.red = BAND_BITS'($urandom_range(2000));
      t = 2 * longint'(b.nir) + 12 * longint'(b.red) + 2 * ONE_FX;
      while (t % 15 != 0) begin
        b.nir = b.nir + 1'b1;
        t = t + 2;
      end
      b.blue = BAND_BITS'(t / 15);
    end else if ($urandom_range(24) == 0) begin
      b = '0;
    end
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(bands_t b, logic typed, index_result_t typed_res);
    while (!in_quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TD_W'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_indices.push_back(typed ? typed_res : predict_index(b));
    pixels_sent++;
    if (pixels_sent == HOLD_AT) hold_request = 1'b1;
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_indices.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(logic [MODE_W-1:0] mode, logic [SOIL_W-1:0] soil);
    logic [CFG_DATA_W-1:0] mode_word;
    settle();
    // junk in the unused upper bits must not reach the mode
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode = mode;
    @(negedge clk);
    cfg_index <= CFG_SOIL_FACTOR;
    cfg_data  <= soil;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_soil = soil;
    @(negedge clk);
    cfg_valid <= 1'b0;
    config_count++;
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  // result sink: random back pressure plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= in_quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    index_result_t want;
    logic signed [OUT_W-1:0] got_value;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got_value = m_axis_tdata[OUT_W-1:0];
        results_seen++;
        if (m_axis_tuser[0]) zero_flags++;
        if (got_value == ONE_S || got_value == NEG_ONE_S) clipped++;
        if (pending_indices.size() == 0) begin
          report_mismatch($sformatf("unexpected result index_value %0d zero %0b",
                                    got_value, m_axis_tuser[0]));
        end else begin
          want = pending_indices.pop_front();
          if (got_value !== want.value || m_axis_tuser[0] !== want.zero_den)
            report_mismatch($sformatf(
              "result %0d: index_value %0d zero %0b, expected %0d zero %0b",
              results_seen, got_value, m_axis_tuser[0], want.value, want.zero_den));
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_indices.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bands_t b;
    index_result_t typed_res;
    logic [MODE_W-1:0] mode;
    logic [SOIL_W-1:0] soil;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (dir_rows[r].mode != cur_mode || dir_rows[r].soil != cur_soil)
        set_config(dir_rows[r].mode, dir_rows[r].soil);
      b.red    = dir_rows[r].red;
      b.nir    = dir_rows[r].nir;
      b.blue   = dir_rows[r].blue;
      b.green  = dir_rows[r].green;
      b.swir   = dir_rows[r].swir;
      typed_res.value    = dir_rows[r].value;
      typed_res.zero_den = dir_rows[r].zero_den;
      if (dir_rows[r].typed) typed_rows++;
      send_pixel(b, dir_rows[r].typed, typed_res);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(9) < 8) mode = MODE_W'($urandom_range(4));
      else mode = MODE_W'($urandom_range(7, 5));
      case ($urandom_range(3))
        0:       soil = '0;
        1:       soil = '1;
        default: soil = SOIL_W'($urandom);
      endcase
      set_config(mode, soil);
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_bands(), 1'b0, '0);
    end

    settle();
    repeat (END_CYCLES) @(negedge clk);

    $display("%0d pixels checked (%0d against typed values) over %0d register settings",
             results_seen, typed_rows, config_count);
    $display("%0d zero-denominator results, %0d clipped to one, %0d mismatches",
             zero_flags, clipped, mismatch_count);
    if (mismatch_count == 0 && pending_indices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
